// ===== design/fixed_step_move_toward_target_assert.svh =====
// assertion macros used by the move-toward-target top level design file
`ifndef FIXED_STEP_MOVE_TOWARD_TARGET_ASSERT_SVH
`define FIXED_STEP_MOVE_TOWARD_TARGET_ASSERT_SVH
`ifndef SYNTHESIS
`define FSTM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("fstm assertion failed");
`define FSTM_ASSERT_NORST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("fstm assertion failed");
`else
`define FSTM_ASSERT(lbl, clk, rstn, prop)
`define FSTM_ASSERT_NORST(lbl, clk, prop)
`endif
`endif

// ===== design/fstm_pkg.sv =====
// shared constants and register codes for the move-toward-target block
package fstm_pkg;
    localparam int COORD_WIDTH_DEF = 24;
    localparam int CFG_WIDTH = 20;
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int QUOT_WIDTH = CFG_WIDTH + 1;
    localparam logic [CFG_WIDTH-1:0] TOL_RESET = 20'd500;
    localparam logic [CFG_WIDTH-1:0] STEP_RESET = 20'd1000;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_TOLERANCE   = 8'd0,
        CFG_STEP_LENGTH = 8'd1
    } t_cfg_index;
endpackage

// ===== design/fstm_sqrt.sv =====
// pipelined floor square root, one result bit per stage
module fstm_sqrt #(
    parameter int RW = 26
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  logic [2*RW-1:0] i_rad,
    output logic [RW-1:0]   o_root
);
    localparam int REMW = RW + 3;

    logic [2*RW-1:0] r_rad  [RW];
    logic [REMW-1:0] r_rem  [RW];
    logic [RW-1:0]   r_root [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [2*RW-1:0] p_rad;
        logic [REMW-1:0] p_rem;
        logic [RW-1:0]   p_root;
        logic [REMW-1:0] rem_sh;
        logic [REMW-1:0] trial;
        logic            ge;

        if (k == 0) begin : g_first
            assign p_rad  = i_rad;
            assign p_rem  = '0;
            assign p_root = '0;
        end else begin : g_next
            assign p_rad  = r_rad[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_root = r_root[k-1];
        end

        assign rem_sh = {p_rem[REMW-3:0], p_rad[2*(RW-1-k)+1 -: 2]};
        assign trial  = {1'b0, p_root, 2'b01};
        assign ge     = rem_sh >= trial;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[k]  <= p_rad;
                r_rem[k]  <= ge ? (rem_sh - trial) : rem_sh;
                r_root[k] <= {p_root[RW-2:0], ge};
            end
        end
    end

    assign o_root = r_root[RW-1];
endmodule

// ===== design/fstm_div.sv =====
// pipelined restoring divider lane, one quotient bit per stage
module fstm_div
    import fstm_pkg::*;
#(
    parameter int NW   = 45,
    parameter int DENW = 26
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [NW-1:0]         i_num,
    input  logic [DENW-1:0]       i_den,
    output logic [QUOT_WIDTH-1:0] o_quot
);
    localparam int QW = QUOT_WIDTH;
    localparam int EW = DENW + QW;

    logic [EW-1:0]   r_rem [QW];
    logic [DENW-1:0] r_den [QW];
    logic [QW-1:0]   r_q   [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        logic [EW-1:0]   p_rem;
        logic [DENW-1:0] p_den;
        logic [QW-1:0]   p_q;
        logic [EW-1:0]   shifted;
        logic            ge;

        if (j == 0) begin : g_first
            assign p_rem = EW'(i_num);
            assign p_den = i_den;
            assign p_q   = '0;
        end else begin : g_next
            assign p_rem = r_rem[j-1];
            assign p_den = r_den[j-1];
            assign p_q   = r_q[j-1];
        end

        assign shifted = EW'(p_den) << (QW - 1 - j);
        assign ge      = p_rem >= shifted;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= ge ? (p_rem - shifted) : p_rem;
                r_den[j] <= p_den;
                r_q[j]   <= {p_q[QW-2:0], ge};
            end
        end
    end

    assign o_quot = r_q[QW-1];
endmodule

// ===== design/fixed_step_move_toward_target.sv =====
// top level of the fixed step move-toward-target pipeline
// Usage:
// Input channel: i_valid / o_stall with target and current point; a transfer
// happens when i_valid is high and o_stall is low.
// Output channel: o_valid / i_stall with next point, snapped flag and
// distance; a transfer happens when o_valid is high and i_stall is low.
// Config channel: i_cfg_valid / o_cfg_ready (always ready); index 0 is the
// tolerance, index 1 the step length. Write only while the pipeline is empty.
// Stages in order: magnitude, square, sum, one square root stage per root bit,
// product, one divider stage per quotient bit in each of three axis lanes,
// then the add and saturate output stage.
// Throughput is one item per cycle while the output is not stalled, set by the
// fully pipelined root and dividers.
// A stall on the output while o_valid is high freezes the whole pipeline, and o_stall follows it.
// Reset clears the valid pipeline and loads tolerance 500, step length 1000.
module fixed_step_move_toward_target
    import fstm_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [COORD_WIDTH-1:0] i_target_x,
    input  logic signed [COORD_WIDTH-1:0] i_target_y,
    input  logic signed [COORD_WIDTH-1:0] i_target_z,
    input  logic signed [COORD_WIDTH-1:0] i_current_x,
    input  logic signed [COORD_WIDTH-1:0] i_current_y,
    input  logic signed [COORD_WIDTH-1:0] i_current_z,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [COORD_WIDTH-1:0] o_next_x,
    output logic signed [COORD_WIDTH-1:0] o_next_y,
    output logic signed [COORD_WIDTH-1:0] o_next_z,
    output logic                       o_snapped,
    output logic [COORD_WIDTH:0]       o_distance_um,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [CFG_WIDTH-1:0]       i_cfg_data
);
`include "fixed_step_move_toward_target_assert.svh"

    localparam int CW   = COORD_WIDTH;
    localparam int DW   = CW + 1;
    localparam int RW   = CW + 2;
    localparam int SUMW = 2 * RW;
    localparam int PW   = DW + CFG_WIDTH;
    localparam int QW   = QUOT_WIDTH;
    localparam int SW   = ((CW > QW) ? CW : QW) + 2;
    localparam int NST  = RW + QW + 5;
    localparam int IPRD = RW + 2;
    localparam int IFIN = NST - 2;

    logic en;
    logic [NST-1:0] r_vld;
    logic [CFG_WIDTH-1:0] r_tol;
    logic [CFG_WIDTH-1:0] r_step;

    logic [2:0][CW-1:0] r_tgt [NST-1];
    logic [2:0][CW-1:0] r_cur [NST-1];
    logic [DW-1:0]   r_mag [3];
    logic [2*DW-1:0] r_sq  [3];
    logic [SUMW-1:0] r_sum;
    logic [RW-1:0]   root;
    logic [PW-1:0]   r_prod [3];
    logic [QW-1:0]   quot   [3];
    logic [RW-1:0]   r_dist [QW+1];
    logic            r_snap [QW+1];
    logic [2:0][CW-1:0] r_next;
    logic            r_snap_o;
    logic [DW-1:0]   r_dist_o;

    function automatic logic [DW-1:0] axis_mag(logic [CW-1:0] t, logic [CW-1:0] c);
        logic [DW-1:0] d;
        d = {t[CW-1], t} - {c[CW-1], c};
        return d[DW-1] ? (DW'(0) - d) : d;
    endfunction

    assign en          = !(r_vld[NST-1] && i_stall);
    assign o_stall     = !en;
    assign o_valid     = r_vld[NST-1];
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol  <= TOL_RESET;
            r_step <= STEP_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_TOLERANCE:   r_tol  <= i_cfg_data;
                CFG_STEP_LENGTH: r_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tgt[0] <= {i_target_z, i_target_y, i_target_x};
            r_cur[0] <= {i_current_z, i_current_y, i_current_x};
            for (int k = 1; k < NST - 1; k++) begin
                r_tgt[k] <= r_tgt[k-1];
                r_cur[k] <= r_cur[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mag[0] <= axis_mag(i_target_x, i_current_x);
            r_mag[1] <= axis_mag(i_target_y, i_current_y);
            r_mag[2] <= axis_mag(i_target_z, i_current_z);
            for (int a = 0; a < 3; a++) begin
                r_sq[a]   <= r_mag[a] * r_mag[a];
                r_prod[a] <= axis_mag(r_tgt[IPRD][a], r_cur[IPRD][a]) * r_step;
            end
            r_sum <= SUMW'(r_sq[0]) + SUMW'(r_sq[1]) + SUMW'(r_sq[2]);
            r_dist[0] <= root;
            r_snap[0] <= root <= RW'(r_tol);
            for (int k = 1; k <= QW; k++) begin
                r_dist[k] <= r_dist[k-1];
                r_snap[k] <= r_snap[k-1];
            end
        end
    end

    fstm_sqrt #(.RW(RW)) u_sqrt (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_rad  (r_sum),
        .o_root (root)
    );

    for (genvar a = 0; a < 3; a++) begin : g_lane
        logic signed [SW-1:0] cur_ext;
        logic signed [SW-1:0] inc;
        logic signed [SW-1:0] sum;
        logic signed [SW-1:0] max_c;
        logic signed [SW-1:0] min_c;
        logic [CW-1:0]        sat;
        logic                 neg;

        fstm_div #(.NW(PW), .DENW(RW)) u_div (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_num  (r_prod[a]),
            .i_den  (r_dist[0]),
            .o_quot (quot[a])
        );

        always_comb begin
            neg     = $signed(r_tgt[IFIN][a]) < $signed(r_cur[IFIN][a]);
            cur_ext = SW'($signed(r_cur[IFIN][a]));
            inc     = neg ? (SW'(0) - SW'(quot[a])) : SW'(quot[a]);
            sum     = cur_ext + inc;
            max_c   = SW'({1'b0, {(CW-1){1'b1}}});
            min_c   = SW'(0) - max_c - SW'(1);
            if (sum > max_c) begin
                sat = {1'b0, {(CW-1){1'b1}}};
            end else if (sum < min_c) begin
                sat = {1'b1, {(CW-1){1'b0}}};
            end else begin
                sat = sum[CW-1:0];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_next[a] <= r_snap[QW] ? r_tgt[IFIN][a] : sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_snap_o <= r_snap[QW];
            r_dist_o <= r_dist[QW][DW-1:0];
        end
    end

    assign o_next_x      = r_next[0];
    assign o_next_y      = r_next[1];
    assign o_next_z      = r_next[2];
    assign o_snapped     = r_snap_o;
    assign o_distance_um = r_dist_o;

    `FSTM_ASSERT(a_snap_within_tol, i_clk, i_rst_n, o_valid && o_snapped |-> o_distance_um <= DW'(r_tol))
    `FSTM_ASSERT(a_move_beyond_tol, i_clk, i_rst_n, o_valid && !o_snapped |-> o_distance_um > DW'(r_tol))
    `FSTM_ASSERT(a_accept_enters, i_clk, i_rst_n, i_valid && !o_stall |=> r_vld[0])
    `FSTM_ASSERT(a_freeze_holds, i_clk, i_rst_n, o_stall |=> $stable(r_vld))
endmodule
